// ===== design/bfras_pkg.sv =====
package bfras_pkg;

  localparam logic [31:0] QNAN32  = 32'h7FC00000;
  localparam logic [31:0] QUIET32 = 32'h00400000;

  localparam logic [0:0] REG_USE_PRE = 1'd0;
  localparam logic [0:0] REG_SCALE   = 1'd1;

  // Unpacked binary32 operand: significand has the hidden bit in place.
  typedef struct packed {
    logic        sign;
    logic [8:0]  exp;     // effective exponent, 1 for subnormals
    logic [23:0] sig;
    logic        is_nan;
    logic        is_inf;
    logic        is_zero;
  } f32_unp_t;

  function automatic logic is_nan32(input logic [31:0] u);
    return (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
  endfunction

  function automatic f32_unp_t unpack32(input logic [31:0] u);
    f32_unp_t r;
    r.sign    = u[31];
    r.exp     = (u[30:23] == 8'd0) ? 9'd1 : {1'b0, u[30:23]};
    r.sig     = {(u[30:23] != 8'd0), u[22:0]};
    r.is_nan  = is_nan32(u);
    r.is_inf  = (u[30:23] == 8'hFF) && (u[22:0] == 23'd0);
    r.is_zero = (u[30:0] == 31'd0);
    return r;
  endfunction

  function automatic logic [31:0] nan_pick(input logic [31:0] x, input logic [31:0] y);
    return (is_nan32(x) ? x : y) | QUIET32;
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] u);
    logic [31:0] t;
    if (is_nan32(u)) begin
      return u[31:16] | 16'h0040;
    end
    t = u + 32'h00007FFF + {31'd0, u[16]};
    return t[31:16];
  endfunction

  // Round and pack: value = mant * 2^(e - 150 - 3) with mant holding
  // 24 significant bits plus guard, round and sticky (27 bits), already
  // normalized so that mant[26] is set unless e has reached the minimum.
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] e,
                                             input logic [26:0] mant);
    logic [24:0] rnd;
    logic        inc;
    logic signed [10:0] ex;
    inc = mant[2] & (mant[1] | mant[0] | mant[3]);
    rnd = {1'b0, mant[26:3]} + {24'd0, inc};
    ex  = e;
    if (rnd[24]) begin
      rnd = rnd >> 1;
      ex  = ex + 11'sd1;
    end
    if (ex >= 11'sd255) begin
      return {sign, 8'hFF, 23'd0};
    end
    if (!rnd[23]) begin
      return {sign, 8'd0, rnd[22:0]};
    end
    return {sign, ex[7:0], rnd[22:0]};
  endfunction

endpackage

// ===== design/bfras_add.sv =====
// Three-stage binary32 adder: align, add, normalize and round.
module bfras_add
  import bfras_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [31:0] sum
);

  // Stage 1: align.
  logic [31:0] s1_special;
  logic        s1_use_special;
  logic        s1_sign_big;
  logic        s1_sub;
  logic [8:0]  s1_exp;
  logic [26:0] s1_big;
  logic [26:0] s1_small;
  logic        s1_zero_both_neg;

  f32_unp_t ux, uy, ub, us;
  logic       swap;
  logic [8:0] diff;
  logic [26:0] sm_ext;
  logic [26:0] sm_sh;
  logic        sticky;
  logic [31:0] spec;
  logic        use_spec;

  always_comb begin
    ux = unpack32(x);
    uy = unpack32(y);
    swap = ({uy.exp, uy.sig} > {ux.exp, ux.sig});
    ub = swap ? uy : ux;
    us = swap ? ux : uy;
    diff = ub.exp - us.exp;
    sm_ext = {us.sig, 3'b000};
    if (diff >= 9'd27) begin
      sm_sh  = 27'd0;
      sticky = (us.sig != 24'd0);
    end else begin
      sm_sh  = sm_ext >> diff[4:0];
      sticky = ((sm_ext & ~(27'h7FFFFFF << diff[4:0])) != 27'd0);
    end
    use_spec = 1'b1;
    spec = 32'd0;
    if (ux.is_nan || uy.is_nan) begin
      spec = nan_pick(x, y);
    end else if (ux.is_inf && uy.is_inf) begin
      spec = (ux.sign == uy.sign) ? x : QNAN32;
    end else if (ux.is_inf) begin
      spec = x;
    end else if (uy.is_inf) begin
      spec = y;
    end else begin
      use_spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_special       <= spec;
      s1_use_special   <= use_spec;
      s1_sign_big      <= ub.sign;
      s1_sub           <= ux.sign ^ uy.sign;
      s1_exp           <= ub.exp;
      s1_big           <= {ub.sig, 3'b000};
      s1_small         <= {sm_sh[26:1], sm_sh[0] | sticky};
      s1_zero_both_neg <= ux.sign & uy.sign;
    end
  end

  // Stage 2: add or subtract, count leading zeros.
  logic [31:0] s2_special;
  logic        s2_use_special;
  logic        s2_sign;
  logic [8:0]  s2_exp;
  logic [27:0] s2_mag;
  logic [4:0]  s2_lz;
  logic        s2_zero;

  logic [27:0] mag;
  logic [4:0]  lz;
  logic        zsign;

  always_comb begin
    if (s1_sub) begin
      mag = {1'b0, s1_big} - {1'b0, s1_small};
    end else begin
      mag = {1'b0, s1_big} + {1'b0, s1_small};
    end
    lz = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (mag[i]) lz = 5'(27 - i);
    end
    zsign = s1_sub ? 1'b0 : s1_zero_both_neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_special     <= s1_special;
      s2_use_special <= s1_use_special;
      s2_sign        <= (mag == 28'd0) ? zsign : s1_sign_big;
      s2_exp         <= s1_exp;
      s2_mag         <= mag;
      s2_lz          <= lz;
      s2_zero        <= (mag == 28'd0);
    end
  end

  // Stage 3: normalize, round, pack.
  logic [26:0] nm;
  logic signed [10:0] ne;
  logic [4:0]  sh;
  logic [31:0] res;

  always_comb begin
    nm = 27'd0;
    ne = 11'sd0;
    sh = 5'd0;
    if (s2_mag[27]) begin
      nm = {s2_mag[27:2], s2_mag[1] | s2_mag[0]};
      ne = $signed({2'b00, s2_exp}) + 11'sd1;
    end else begin
      // shift left by lz-1, limited so the exponent stays at least 1
      if ({4'd0, s2_lz} - 9'd1 > s2_exp - 9'd1) begin
        sh = 5'(s2_exp - 9'd1);
      end else begin
        sh = s2_lz - 5'd1;
      end
      nm = s2_mag[26:0] << sh;
      ne = $signed({2'b00, s2_exp}) - $signed({6'd0, sh});
    end
    if (s2_use_special) begin
      res = s2_special;
    end else if (s2_zero) begin
      res = {s2_sign, 31'd0};
    end else begin
      res = round_pack(s2_sign, ne, nm);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= res;
    end
  end

endmodule

// ===== design/bfras_mul.sv =====
// Three-stage binary32 multiplier: multiply, normalize, round.
module bfras_mul
  import bfras_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [31:0] prod
);

  f32_unp_t ux, uy;
  logic [31:0] spec;
  logic        use_spec;

  always_comb begin
    ux = unpack32(x);
    uy = unpack32(y);
    use_spec = 1'b1;
    spec = 32'd0;
    if (ux.is_nan || uy.is_nan) begin
      spec = nan_pick(x, y);
    end else if ((ux.is_inf && uy.is_zero) || (uy.is_inf && ux.is_zero)) begin
      spec = QNAN32;
    end else if (ux.is_inf || uy.is_inf) begin
      spec = {ux.sign ^ uy.sign, 8'hFF, 23'd0};
    end else if (ux.is_zero || uy.is_zero) begin
      spec = {ux.sign ^ uy.sign, 31'd0};
    end else begin
      use_spec = 1'b0;
    end
  end

  // Stage 1: product.
  logic [31:0] s1_special;
  logic        s1_use_special;
  logic        s1_sign;
  logic signed [10:0] s1_exp;
  logic [47:0] s1_p;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_special     <= spec;
      s1_use_special <= use_spec;
      s1_sign        <= ux.sign ^ uy.sign;
      s1_exp         <= $signed({2'b00, ux.exp}) + $signed({2'b00, uy.exp}) - 11'sd126;
      s1_p           <= {24'd0, ux.sig} * {24'd0, uy.sig};
    end
  end

  // Stage 2: leading-zero count (product value = p * 2^(exp-1-150-23+...)).
  logic [5:0] lz;
  always_comb begin
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (s1_p[i]) lz = 6'(47 - i);
    end
  end

  logic [31:0] s2_special;
  logic        s2_use_special;
  logic        s2_sign;
  logic signed [10:0] s2_exp;
  logic [47:0] s2_p;
  logic [5:0]  s2_lz;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_special     <= s1_special;
      s2_use_special <= s1_use_special;
      s2_sign        <= s1_sign;
      s2_exp         <= s1_exp;
      s2_p           <= s1_p;
      s2_lz          <= lz;
    end
  end

  // Stage 3: normalize (left or right for subnormals), round, pack.
  // With p[47] set, the value has exponent field s2_exp.
  logic signed [10:0] e_norm;
  logic [47:0] pn;
  logic [74:0] wide;
  logic [26:0] m;
  logic signed [10:0] e_out;
  logic [5:0]  rs;
  logic [31:0] res;

  always_comb begin
    e_norm = s2_exp - $signed({5'd0, s2_lz});
    pn = s2_p << s2_lz;
    rs = 6'd0;
    wide = {pn, 27'd0};
    e_out = e_norm;
    if (e_norm < 11'sd1) begin
      if (11'sd1 - e_norm > 11'sd40) begin
        rs = 6'd40;
      end else begin
        rs = 6'(11'sd1 - e_norm);
      end
      wide = {pn, 27'd0} >> rs;
      e_out = 11'sd1;
    end
    m = {wide[74:49], wide[48:0] != 49'd0};
    if (s2_use_special) begin
      res = s2_special;
    end else begin
      res = round_pack(s2_sign, e_out, m);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= res;
    end
  end

endmodule

// ===== design/bf16_residual_add_scale.sv =====
// Elementwise bf16 residual add with output scale. Each transfer on the
// input stream carries one element of a, b and pre; the block widens them to
// binary32, adds a and b, optionally adds pre to the bf16-rounded sum, then
// multiplies by scale_bits and rounds to bf16. A new element is taken every
// cycle unless the output stalls; the pipeline is two three-stage adders
// and a three-stage multiplier plus an output register.
// The whole pipeline advances only when its last stage can move, so a stall
// on the output holds every stage. Write configuration only while idle.
module bf16_residual_add_scale
  import bfras_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // a_val, b_val, pre_val
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // result_val
);

  localparam int Depth = 10;

  logic        use_pre_residual;
  logic [31:0] scale_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_pre_residual <= 1'b0;
      scale_bits       <= 32'h3F800000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USE_PRE: use_pre_residual <= cfg_data[0];
        REG_SCALE:   scale_bits       <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [Depth-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], s_axis_tvalid};
    end
  end

  // Pre-residual delayed alongside the first adder.
  logic [15:0] pre_d [3];
  always_ff @(posedge clk) begin
    if (en) begin
      pre_d[0] <= s_axis_tdata[47:32];
      pre_d[1] <= pre_d[0];
      pre_d[2] <= pre_d[1];
    end
  end

  logic [31:0] sum1, sum2, s_sel, prod;
  logic [31:0] sum1_d [3];

  bfras_add u_add1 (
    .clk(clk), .en(en),
    .x({s_axis_tdata[15:0], 16'd0}), .y({s_axis_tdata[31:16], 16'd0}),
    .sum(sum1)
  );

  bfras_add u_add2 (
    .clk(clk), .en(en),
    .x({pre_d[2], 16'd0}), .y({to_bf16(sum1), 16'd0}),
    .sum(sum2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sum1_d[0] <= sum1;
      sum1_d[1] <= sum1_d[0];
      sum1_d[2] <= sum1_d[1];
    end
  end

  assign s_sel = use_pre_residual ? sum2 : sum1_d[2];

  bfras_mul u_mul (
    .clk(clk), .en(en), .x(s_sel), .y(scale_bits), .prod(prod)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= to_bf16(prod);
    end
  end

endmodule
